// ----- rtl/core/utf16_to_utf8_encoder_defines.svh -----
// Assertion macros for the UTF-16 to UTF-8 encoder.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef UTF16_TO_UTF8_ENCODER_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTFENC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utfenc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define UTFENC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utfenc: next-cycle check failed");

`endif

// ----- rtl/core/utfenc_pkg.sv -----
package utfenc_pkg;

    // Run queue between the classifier and the byte emitter
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [15:0] ASCII_LIMIT    = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [15:0] SURR_LO        = 16'hD800;
    localparam logic [15:0] SURR_HI        = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;

    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] CONT  = 8'h80;

    // Index of the final byte of a run
    localparam logic [1:0] RUN_ONE   = 2'd0;
    localparam logic [1:0] RUN_TWO   = 2'd1;
    localparam logic [1:0] RUN_THREE = 2'd2;
    localparam logic [1:0] RUN_FOUR  = 2'd3;

    typedef struct packed {
        logic [1:0]      n_last;
        logic [3:0][7:0] bytes;   // bytes[0] goes out first
    } run_t;

    typedef struct packed {
        logic push;
        run_t run;
    } q_wr_t;

    typedef struct packed {
        logic lead_pending;
    } front_stat_t;

endpackage

// ----- rtl/core/utfenc_if.sv -----
interface utfenc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, code_unit, last_unit, input ready);
    modport sink   (input valid, code_unit, last_unit, output ready);
endinterface

interface utfenc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       char_done;

    modport source (output valid, out_byte, char_done, input ready);
    modport sink   (input valid, out_byte, char_done, output ready);
endinterface

// ----- rtl/core/utfenc_front.sv -----
module utfenc_front (
    input  logic                     clk,
    input  logic                     rst_n,
    utfenc_in_if.sink                units,
    input  logic                     q_full,
    output utfenc_pkg::q_wr_t        wr,
    output utfenc_pkg::front_stat_t  stat
);

    logic              lead_pending_reg, lead_pending_next;
    logic [9:0]        lead_bits_reg, lead_bits_next;
    logic              accept;
    logic              has_bytes;
    logic [15:0]       unit;
    logic [20:0]       cp;
    utfenc_pkg::run_t  run;

    assign units.ready = !q_full;
    assign accept      = units.valid && units.ready;
    assign unit        = units.code_unit;
    assign cp          = utfenc_pkg::SUPP_BASE + 21'({lead_bits_reg, unit[9:0]});

    always_comb
    begin
        run               = '0;
        has_bytes         = 1'b0;
        lead_pending_next = lead_pending_reg;
        lead_bits_next    = lead_bits_reg;
        if (lead_pending_reg)
        begin
            // any unit completes the pair
            has_bytes         = 1'b1;
            run.n_last        = utfenc_pkg::RUN_FOUR;
            run.bytes[0]      = utfenc_pkg::LEAD4 | {5'b0, cp[20:18]};
            run.bytes[1]      = utfenc_pkg::CONT  | {2'b0, cp[17:12]};
            run.bytes[2]      = utfenc_pkg::CONT  | {2'b0, cp[11:6]};
            run.bytes[3]      = utfenc_pkg::CONT  | {2'b0, cp[5:0]};
            lead_pending_next = 1'b0;
            lead_bits_next    = '0;
        end
        else if (unit == 16'h0000)
        begin
            has_bytes = 1'b0;   // terminator: drop
        end
        else if (unit < utfenc_pkg::ASCII_LIMIT)
        begin
            has_bytes    = 1'b1;
            run.n_last   = utfenc_pkg::RUN_ONE;
            run.bytes[0] = unit[7:0];
        end
        else if (unit < utfenc_pkg::TWO_BYTE_LIMIT)
        begin
            has_bytes    = 1'b1;
            run.n_last   = utfenc_pkg::RUN_TWO;
            run.bytes[0] = utfenc_pkg::LEAD2 | {3'b0, unit[10:6]};
            run.bytes[1] = utfenc_pkg::CONT  | {2'b0, unit[5:0]};
        end
        else if (unit inside {[utfenc_pkg::SURR_LO:utfenc_pkg::SURR_HI]})
        begin
            if (!units.last_unit)
            begin
                lead_pending_next = 1'b1;
                lead_bits_next    = unit[9:0];
            end
        end
        else
        begin
            has_bytes    = 1'b1;
            run.n_last   = utfenc_pkg::RUN_THREE;
            run.bytes[0] = utfenc_pkg::LEAD3 | {4'b0, unit[15:12]};
            run.bytes[1] = utfenc_pkg::CONT  | {2'b0, unit[11:6]};
            run.bytes[2] = utfenc_pkg::CONT  | {2'b0, unit[5:0]};
        end
        if (units.last_unit)
        begin
            lead_pending_next = 1'b0;
            lead_bits_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_bits_reg    <= '0;
        end
        else if (accept)
        begin
            lead_pending_reg <= lead_pending_next;
            lead_bits_reg    <= lead_bits_next;
        end
    end

    assign wr.push           = accept && has_bytes;
    assign wr.run            = run;
    assign stat.lead_pending = lead_pending_reg;

endmodule

// ----- rtl/core/utfenc_fifo.sv -----
module utfenc_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  utfenc_pkg::q_wr_t  wr,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output utfenc_pkg::run_t   head
);

    utfenc_pkg::run_t                   mem [utfenc_pkg::QDEPTH];
    logic [utfenc_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [utfenc_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [utfenc_pkg::QCNT_W-1:0]      count_reg, count_next;

    function automatic logic [utfenc_pkg::QPTR_W-1:0] ptr_inc(
        input logic [utfenc_pkg::QPTR_W-1:0] p);
        if (p == utfenc_pkg::QPTR_W'(utfenc_pkg::QDEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    assign full      = (count_reg == utfenc_pkg::QCNT_W'(utfenc_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr.push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({wr.push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
            mem[wr_ptr_reg] <= wr.run;
    end

endmodule

// ----- rtl/core/utfenc_back.sv -----
module utfenc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  utfenc_pkg::run_t  q_head,
    output logic              q_pop,
    utfenc_out_if.source      octets
);

    logic            valid_reg, valid_next;
    logic [1:0]      left_reg, left_next;
    logic [3:0][7:0] bytes_reg, bytes_next;
    logic            take;
    logic            load_ok;

    assign take    = valid_reg && octets.ready;
    // load the next run once the current one has handed out its final byte
    assign load_ok = !valid_reg || (take && left_reg == 2'd0);
    assign q_pop   = load_ok && q_not_empty;

    always_comb
    begin
        valid_next = valid_reg;
        left_next  = left_reg;
        bytes_next = bytes_reg;
        if (load_ok)
        begin
            valid_next = q_not_empty;
            if (q_not_empty)
            begin
                left_next  = q_head.n_last;
                bytes_next = q_head.bytes;
            end
        end
        else if (take)
        begin
            // advance to the next byte of the run
            left_next  = left_reg - 1'b1;
            bytes_next = {8'h00, bytes_reg[3:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        bytes_reg <= bytes_next;
    end

    assign octets.valid     = valid_reg;
    assign octets.out_byte  = bytes_reg[0];
    assign octets.char_done = (left_reg == 2'd0);

endmodule

// ----- rtl/core/utf16_to_utf8_encoder.sv -----
// Channel   Role    Payload                         Item
// units     sink    code_unit[15:0], last_unit      one UTF-16 code unit
// octets    source  out_byte[7:0], char_done        one UTF-8 byte
//
// One code unit is taken per cycle while the two-run queue has room; a unit
// giving n bytes occupies the byte emitter, one byte a cycle while octets.ready is high.
// Sustained rate is set by the emitter's shift register.
// Reset (rst_n low, asynchronous) clears the pending lead and empties the queue.
// A stall on octets fills the queue, then drops units.ready.
`include "utf16_to_utf8_encoder_defines.svh"

module utf16_to_utf8_encoder (
    input  logic          clk,
    input  logic          rst_n,
    utfenc_in_if.sink     units,
    utfenc_out_if.source  octets
);

    utfenc_pkg::q_wr_t        wr;
    utfenc_pkg::front_stat_t  stat;
    utfenc_pkg::run_t         q_head;
    logic                     q_full;
    logic                     q_not_empty;
    logic                     q_pop;

    utfenc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .units  (units),
        .q_full (q_full),
        .wr     (wr),
        .stat   (stat)
    );

    utfenc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    utfenc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .octets      (octets)
    );

    // a unit after a lead always queues a four-byte run
    `UTFENC_ASSERT_NOW(a_pair_run, stat.lead_pending && units.valid && units.ready, wr.push && (wr.run.n_last == utfenc_pkg::RUN_FOUR))

    // a unit marked last leaves no lead behind
    `UTFENC_ASSERT_NEXT(a_last_clears, units.valid && units.ready && units.last_unit, !stat.lead_pending)

    // a run is emitted without gaps until its final byte
    `UTFENC_ASSERT_NEXT(a_run_gapless, octets.valid && octets.ready && !octets.char_done, octets.valid)

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned UNIT_TARGET  = 225;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned PRINT_CAP    = 40;

    typedef struct packed {
        logic [7:0] octet;
        logic       done;
    } octet_t;

    typedef enum int {
        KIND_ASCII,
        KIND_TWO,
        KIND_THREE,
        KIND_PAIR
    } char_kind_t;

    logic clk;
    logic rst_n;

    utfenc_in_if  units_if ();
    utfenc_out_if octets_if ();

    utf16_to_utf8_encoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .units  (units_if),
        .octets (octets_if)
    );

    // Predictor state
    logic       lead_waiting = 1'b0;
    logic [9:0] lead_low     = '0;
    octet_t     octets_due[$];

    int unsigned err_count      = 0;
    int unsigned units_accepted = 0;
    int unsigned octets_checked = 0;
    int unsigned pairs_sent     = 0;
    int unsigned strings_sent   = 0;
    int unsigned idle_count;
    bit          no_idle        = 1'b0;

    initial clk = 1'b0;

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Compute the UTF-8 bytes for one accepted code unit and queue them.
    function automatic void predict_octets(input logic [15:0] cu, input logic lst);
        logic [20:0] cp;
        logic [7:0]  b [4];
        int          n;
        n = 0;
        if (lead_waiting)
        begin
            cp = utfenc_pkg::SUPP_BASE + {1'b0, lead_low, 10'b0} + {11'b0, cu[9:0]};
            b[0] = utfenc_pkg::LEAD4 | {5'b0, cp[20:18]};
            b[1] = utfenc_pkg::CONT  | {2'b0, cp[17:12]};
            b[2] = utfenc_pkg::CONT  | {2'b0, cp[11:6]};
            b[3] = utfenc_pkg::CONT  | {2'b0, cp[5:0]};
            n = 4;
            lead_waiting = 1'b0;
            lead_low = '0;
        end
        else if (cu == 16'h0000)
        begin
            n = 0;
        end
        else if (cu < utfenc_pkg::ASCII_LIMIT)
        begin
            b[0] = cu[7:0];
            n = 1;
        end
        else if (cu < utfenc_pkg::TWO_BYTE_LIMIT)
        begin
            b[0] = utfenc_pkg::LEAD2 | {3'b0, cu[10:6]};
            b[1] = utfenc_pkg::CONT  | {2'b0, cu[5:0]};
            n = 2;
        end
        else if (cu >= utfenc_pkg::SURR_LO && cu <= utfenc_pkg::SURR_HI)
        begin
            if (!lst)
            begin
                lead_waiting = 1'b1;
                lead_low = cu[9:0];
            end
        end
        else
        begin
            b[0] = utfenc_pkg::LEAD3 | {4'b0, cu[15:12]};
            b[1] = utfenc_pkg::CONT  | {2'b0, cu[11:6]};
            b[2] = utfenc_pkg::CONT  | {2'b0, cu[5:0]};
            n = 3;
        end
        if (lst)
        begin
            lead_waiting = 1'b0;
            lead_low = '0;
        end
        for (int i = 0; i < n; i++)
            octets_due.push_back('{octet: b[i], done: (i == n - 1)});
    endfunction

    // Watch both channels; inputs first so a same-edge byte finds its expectation.
    always @(posedge clk)
    begin
        octet_t want;
        if (rst_n)
        begin
            if (units_if.valid && units_if.ready)
            begin
                predict_octets(units_if.code_unit, units_if.last_unit);
                units_accepted++;
            end
            if (octets_if.valid && octets_if.ready)
            begin
                if (octets_due.size() == 0)
                begin
                    report_mismatch("unexpected byte", octets_if.out_byte, 0);
                end
                else
                begin
                    want = octets_due.pop_front();
                    if (octets_if.out_byte !== want.octet)
                        report_mismatch("out_byte", octets_if.out_byte, want.octet);
                    if (octets_if.char_done !== want.done)
                        report_mismatch("char_done", octets_if.char_done, want.done);
                    octets_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_count <= 0;
        end
        else
        begin
            if ((units_if.valid && units_if.ready) || (octets_if.valid && octets_if.ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= STALL_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Output back-pressure: ready runs of random length with random stalls between.
    initial
    begin
        int run;
        int gap;
        octets_if.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
            octets_if.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                octets_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Leaves the caller at the edge where the item was accepted; valid stays high.
    task automatic send_unit(input logic [15:0] cu, input logic lst);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            units_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        units_if.valid     <= 1'b1;
        units_if.code_unit <= cu;
        units_if.last_unit <= lst;
        @(posedge clk);
        while (!units_if.ready)
            @(posedge clk);
    endtask

    task automatic send_pair(input logic [9:0] hi, input logic [9:0] lo, input logic lst);
        send_unit(utfenc_pkg::SURR_LO | {6'b0, hi}, 1'b0);
        send_unit(16'hDC00 | {6'b0, lo}, lst);
        pairs_sent++;
    endtask

    task automatic test_single_byte();
        send_unit(16'h0001, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h007F, 1'b1);
    endtask

    task automatic test_two_byte();
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b1);
    endtask

    task automatic test_three_byte();
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
    endtask

    task automatic test_surrogate_pairs();
        send_pair(10'h000, 10'h000, 1'b0);
        send_pair(10'h3FF, 10'h3FF, 1'b1);
        // Zero, a second surrogate and plain ASCII all act as the trail
        send_unit(16'hD83D, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'hDA55, 1'b0);
        send_unit(16'hD9AA, 1'b0);
        send_unit(16'hDBC0, 1'b0);
        send_unit(16'h0041, 1'b1);
    endtask

    task automatic test_terminators();
        send_unit(16'h0000, 1'b0);
        send_unit(16'h0000, 1'b1);
        // Lead marked last is dropped; the following unit stands alone
        send_unit(16'hD800, 1'b1);
        send_unit(16'h0042, 1'b0);
        // Stray trail becomes a lead
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDC01, 1'b1);
        send_unit(16'hDFFF, 1'b1);
        send_unit(16'h0043, 1'b1);
    endtask

    task automatic test_random_strings();
        int          len;
        char_kind_t  kind;
        logic        end_by_flag;
        logic        lst;
        logic [15:0] cu;
        while (units_accepted < UNIT_TARGET)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85)
            begin
                len = $urandom_range(1, 8);
                end_by_flag = 1'($urandom_range(0, 1));
                for (int i = 0; i < len; i++)
                begin
                    lst = end_by_flag && (i == len - 1);
                    kind = char_kind_t'($urandom_range(0, 3));
                    case (kind)
                        KIND_ASCII: send_unit(16'($urandom_range(1, 16'h7F)), lst);
                        KIND_TWO:   send_unit(16'($urandom_range(16'h80, 16'h7FF)), lst);
                        KIND_THREE:
                        begin
                            if ($urandom_range(0, 1))
                                cu = 16'($urandom_range(16'h800, 16'hD7FF));
                            else
                                cu = 16'($urandom_range(16'hE000, 16'hFFFF));
                            send_unit(cu, lst);
                        end
                        default:    send_pair(10'($urandom), 10'($urandom), lst);
                    endcase
                end
                if (!end_by_flag)
                    send_unit(16'h0000, 1'($urandom_range(0, 1)));
                strings_sent++;
            end
            else
            begin
                // Noise: arbitrary units and end flags
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_unit(16'($urandom), ($urandom_range(0, 3) == 0));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        units_if.valid     <= 1'b0;
        units_if.code_unit <= '0;
        units_if.last_unit <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_single_byte();
        test_two_byte();
        test_three_byte();
        test_surrogate_pairs();
        test_terminators();
        test_random_strings();

        units_if.valid <= 1'b0;
        while (octets_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (octets_due.size() != 0)
            report_mismatch("bytes never emitted", 0, octets_due.size());

        $display("Encoded %0d code units (%0d well-formed strings, %0d surrogate pairs)",
                 units_accepted, strings_sent, pairs_sent);
        $display("Compared %0d UTF-8 bytes, %0d mismatches", octets_checked, err_count);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/utfenc_pkg.sv
rtl/core/utfenc_if.sv
rtl/core/utfenc_front.sv
rtl/core/utfenc_fifo.sv
rtl/core/utfenc_back.sv
rtl/core/utf16_to_utf8_encoder.sv
verif/tb_top.sv
